FILE: rtl/ert_pkg.sv
// Shared constants, widths and the arctangent table of the 3D rotation block.
package ert_pkg;

	localparam int COORD_WIDTH_DEF  = 40;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int IT_W             = 5;
	localparam int ANGLE_W          = 26;
	localparam int ANG_EXT_W        = 27;
	localparam int OP_W             = 33;
	localparam int COEF_W           = 34;
	localparam int CORDIC_W         = 34;
	localparam int CFG_INDEX_W      = 3;

	localparam logic signed [ANG_EXT_W-1:0] DEG_FULL    = 27'sd23592960;
	localparam logic signed [ANG_EXT_W-1:0] DEG_HALF    = 27'sd11796480;
	localparam logic signed [ANG_EXT_W-1:0] DEG_QUARTER = 27'sd5898240;
	localparam logic [61:0] DEG2RAD_Q44 = 62'd307041569099;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADING  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PITCH    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROLL     = 3'd5;

	// Arctangent of 2^-i in radians, Q.30, rounded down.
	function automatic logic [30:0] atan_q30(input logic [IT_W-1:0] i);
		logic [30:0] r;
		case (i)
			5'd0: r = 31'd843314856;
			5'd1: r = 31'd497837829;
			5'd2: r = 31'd263043836;
			5'd3: r = 31'd133525158;
			5'd4: r = 31'd67021686;
			5'd5: r = 31'd33543515;
			5'd6: r = 31'd16775850;
			5'd7: r = 31'd8388437;
			5'd8: r = 31'd4194282;
			5'd9: r = 31'd2097149;
			5'd10: r = 31'd1048575;
			5'd11: r = 31'd524287;
			5'd12: r = 31'd262143;
			5'd13: r = 31'd131071;
			5'd14: r = 31'd65535;
			5'd15: r = 31'd32767;
			5'd16: r = 31'd16383;
			5'd17: r = 31'd8191;
			5'd18: r = 31'd4095;
			5'd19: r = 31'd2047;
			5'd20: r = 31'd1023;
			5'd21: r = 31'd511;
			5'd22: r = 31'd255;
			5'd23: r = 31'd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/ert_if.sv
// Handshake interfaces for the point and result channels.
interface ert_point_if import ert_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;

	modport source (output valid, command, point_x, point_y, point_z, input ready);
	modport sink (input valid, command, point_x, point_y, point_z, output ready);
endinterface

interface ert_result_if import ert_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] result_x;
	logic signed [COORD_WIDTH-1:0] result_y;
	logic signed [COORD_WIDTH-1:0] result_z;

	modport source (output valid, result_x, result_y, result_z, input ready);
	modport sink (input valid, result_x, result_y, result_z, output ready);
endinterface

FILE: rtl/euler_rotation_3d_translate.sv
// Euler-angle rotation of 3D points about a reference origin, with a pipelined datapath.
//
// The points channel carries one item per point: a command (forward or inverse) and
// three signed coordinates with 16 fractional bits. The results channel returns one
// item per point, the transformed coordinates saturated to the coordinate range.
// Forward mode subtracts the origin and rotates by R = Ry(roll)*Rx(pitch)*Rz(heading
// term); inverse mode rotates by the transpose of R and adds the origin back.
//
// The datapath has five register stages (operand select, partial products, product
// assembly, accumulation, rounding and saturation), and a new point may be accepted in
// every cycle while the output register is free and the matrix is not being rebuilt.
// When the receiver holds ready low while a result waits in the output register, the
// whole pipeline freezes and points are held off; nothing is dropped or repeated.
//
// The rotation matrix depends only on the angle registers. It is rebuilt by a small
// sequencer with one shared CORDIC and one shared 33x33 multiplier. This runs after
// reset and after every write to an angle register; points are refused while it runs.
// Reset clears the origin and angle registers to zero, but not the matrix or datapath.
module euler_rotation_3d_translate import ert_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [(COORD_WIDTH > ANGLE_W ? COORD_WIDTH : ANGLE_W)-1:0] cfg_wdata,
	ert_point_if.sink              points,
	ert_result_if.source           results
);

	localparam int W      = COORD_WIDTH;
	localparam int DW     = W + 1;
	localparam int LO_W   = DW / 2;
	localparam int HI_W   = DW - LO_W;
	localparam int ACC_W  = W + COEF_W + 3;
	localparam int NSTEP  = CORDIC_STEPS > ATAN_ENTRIES ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam int PLO_W  = LO_W + 1 + COEF_W;
	localparam int PHI_W  = HI_W + COEF_W;

	typedef enum logic [2:0] {
		S_IDLE, S_PREP, S_SCALE, S_ITER, S_STORE, S_MUL, S_RND, S_MAT
	} state_t;

	// Configuration registers.
	logic signed [W-1:0]       origin_q [3];
	logic signed [ANGLE_W-1:0] angle_q  [3];
	logic                      angle_wr;

	assign angle_wr = cfg_wen && (cfg_index == CFG_HEADING || cfg_index == CFG_PITCH
		|| cfg_index == CFG_ROLL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				angle_q[i]  <= '0;
			end
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: origin_q[0] <= cfg_wdata[W-1:0];
				CFG_ORIGIN_Y: origin_q[1] <= cfg_wdata[W-1:0];
				CFG_ORIGIN_Z: origin_q[2] <= cfg_wdata[W-1:0];
				CFG_HEADING:  angle_q[0]  <= cfg_wdata[ANGLE_W-1:0];
				CFG_PITCH:    angle_q[1]  <= cfg_wdata[ANGLE_W-1:0];
				CFG_ROLL:     angle_q[2]  <= cfg_wdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Matrix sequencer: angle reduction, CORDIC, then the fourteen products and the matrix.
	state_t                      state_q;
	logic [1:0]                  ang_q;
	logic signed [ANG_EXT_W-1:0] a_q;
	logic                        flip_q;
	logic [IT_W-1:0]             it_q;
	logic signed [CORDIC_W-1:0]  x_q, y_q, z_q;
	logic signed [OP_W-1:0]      sin_q [3];
	logic signed [OP_W-1:0]      cos_q [3];
	logic [3:0]                  k_q;
	logic signed [2*OP_W-1:0]    raw_q;
	logic signed [OP_W-1:0]      prod_q [14];
	logic signed [COEF_W-1:0]    m_q [3][3];

	logic signed [ANG_EXT_W-1:0] a0, a1, a2, a3;
	logic                        flip_d;
	logic [22:0]                 mag;
	logic [61:0]                 scaled;
	logic [31:0]                 zmag;
	logic signed [CORDIC_W-1:0]  dx, dy, at;
	logic signed [OP_W-1:0]      opa, opb;
	logic signed [2*OP_W-1:0]    raw_rnd;

	always_comb begin
		a0 = ANG_EXT_W'(angle_q[ang_q]);
		if (a0 >= DEG_FULL)
			a1 = a0 - DEG_FULL;
		else if (a0 <= -DEG_FULL)
			a1 = a0 + DEG_FULL;
		else
			a1 = a0;
		if (a1 >= DEG_HALF)
			a2 = a1 - DEG_FULL;
		else if (a1 < -DEG_HALF)
			a2 = a1 + DEG_FULL;
		else
			a2 = a1;
		flip_d = 1'b1;
		if (a2 > DEG_QUARTER)
			a3 = a2 - DEG_HALF;
		else if (a2 < -DEG_QUARTER)
			a3 = a2 + DEG_HALF;
		else begin
			a3 = a2;
			flip_d = 1'b0;
		end
		mag    = a_q[ANG_EXT_W-1] ? 23'(-a_q) : 23'(a_q);
		scaled = {39'd0, mag} * DEG2RAD_Q44;
		zmag   = 32'((scaled + 62'd536870912) >> 30);
		dx     = y_q >>> it_q;
		dy     = x_q >>> it_q;
		at     = CORDIC_W'(atan_q30(it_q));
		raw_rnd = raw_q + (2*OP_W)'(64'd536870912);
	end

	// Operand pairs of the fourteen rounded products, in order of use.
	always_comb begin
		case (k_q)
			4'd0:  begin opa = sin_q[1]; opb = sin_q[0];  end
			4'd1:  begin opa = sin_q[1]; opb = cos_q[0];  end
			4'd2:  begin opa = cos_q[2]; opb = cos_q[0];  end
			4'd3:  begin opa = sin_q[2]; opb = prod_q[0]; end
			4'd4:  begin opa = cos_q[2]; opb = sin_q[0];  end
			4'd5:  begin opa = sin_q[2]; opb = prod_q[1]; end
			4'd6:  begin opa = sin_q[2]; opb = cos_q[1];  end
			4'd7:  begin opa = cos_q[1]; opb = sin_q[0];  end
			4'd8:  begin opa = cos_q[1]; opb = cos_q[0];  end
			4'd9:  begin opa = sin_q[2]; opb = cos_q[0];  end
			4'd10: begin opa = cos_q[2]; opb = prod_q[0]; end
			4'd11: begin opa = sin_q[2]; opb = sin_q[0];  end
			4'd12: begin opa = cos_q[2]; opb = prod_q[1]; end
			default: begin opa = cos_q[2]; opb = cos_q[1]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_PREP;
			ang_q   <= '0;
			it_q    <= '0;
			k_q     <= '0;
		end else if (angle_wr) begin
			state_q <= S_PREP;
			ang_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: ;
				S_PREP: begin
					a_q     <= a3;
					flip_q  <= flip_d;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					z_q     <= a_q[ANG_EXT_W-1] ? -CORDIC_W'(zmag) : CORDIC_W'(zmag);
					x_q     <= CORDIC_GAIN_INV;
					y_q     <= '0;
					it_q    <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (!z_q[CORDIC_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(NSTEP - 1))
						state_q <= S_STORE;
				end
				S_STORE: begin
					cos_q[ang_q] <= OP_W'(flip_q ? -x_q : x_q);
					sin_q[ang_q] <= OP_W'(flip_q ? -y_q : y_q);
					if (ang_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_MUL;
					end else begin
						ang_q   <= ang_q + 1'b1;
						state_q <= S_PREP;
					end
				end
				S_MUL: begin
					raw_q   <= opa * opb;
					state_q <= S_RND;
				end
				S_RND: begin
					prod_q[k_q] <= OP_W'(raw_rnd >>> 30);
					k_q         <= k_q + 1'b1;
					state_q     <= (k_q == 4'd13) ? S_MAT : S_MUL;
				end
				S_MAT: begin
					m_q[0][0] <= COEF_W'(prod_q[2]) + COEF_W'(prod_q[3]);
					m_q[0][1] <= COEF_W'(prod_q[5]) - COEF_W'(prod_q[4]);
					m_q[0][2] <= -COEF_W'(prod_q[6]);
					m_q[1][0] <= COEF_W'(prod_q[7]);
					m_q[1][1] <= COEF_W'(prod_q[8]);
					m_q[1][2] <= COEF_W'(sin_q[1]);
					m_q[2][0] <= COEF_W'(prod_q[9]) - COEF_W'(prod_q[10]);
					m_q[2][1] <= -COEF_W'(prod_q[11]) - COEF_W'(prod_q[12]);
					m_q[2][2] <= COEF_W'(prod_q[13]);
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Point pipeline. All stages advance together whenever the output register is free.
	logic adv, take;
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;
	logic signed [DW-1:0]     d_s1    [3];
	logic signed [COEF_W-1:0] coef_s1 [3][3];
	logic signed [W-1:0]      org_s1  [3];
	logic signed [PLO_W-1:0]  plo_s2  [3][3];
	logic signed [PHI_W-1:0]  phi_s2  [3][3];
	logic signed [W-1:0]      org_s2  [3];
	logic signed [ACC_W-1:0]  term_s3 [3][3];
	logic signed [W-1:0]      org_s3  [3];
	logic signed [ACC_W-1:0]  sum_s4  [3];
	logic signed [W-1:0]      res_q   [3];
	logic signed [W-1:0]      pt      [3];
	logic signed [ACC_W-1:0]  shv     [3];

	assign adv           = !res_valid_q || results.ready;
	assign points.ready  = adv && (state_q == S_IDLE) && !angle_wr;
	assign take          = points.valid && points.ready;
	assign results.valid    = res_valid_q;
	assign results.result_x = res_q[0];
	assign results.result_y = res_q[1];
	assign results.result_z = res_q[2];
	assign pt[0] = points.point_x;
	assign pt[1] = points.point_y;
	assign pt[2] = points.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++)
			shv[i] = sum_s4[i] >>> 30;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= take;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: origin difference or the point, and plain or transposed coefficients.
			for (int i = 0; i < 3; i++) begin
				if (points.command) begin
					d_s1[i]   <= DW'(pt[i]);
					org_s1[i] <= origin_q[i];
				end else begin
					d_s1[i]   <= DW'(pt[i]) - DW'(origin_q[i]);
					org_s1[i] <= '0;
				end
				for (int j = 0; j < 3; j++)
					coef_s1[i][j] <= points.command ? m_q[j][i] : m_q[i][j];
			end
			// Stage 2: each coordinate is split into two halves for the multipliers.
			for (int i = 0; i < 3; i++) begin
				org_s2[i] <= org_s1[i];
				for (int j = 0; j < 3; j++) begin
					plo_s2[i][j] <= $signed({1'b0, d_s1[j][LO_W-1:0]}) * coef_s1[i][j];
					phi_s2[i][j] <= $signed(d_s1[j][DW-1:LO_W]) * coef_s1[i][j];
				end
			end
			// Stage 3: the halves are joined into full products.
			for (int i = 0; i < 3; i++) begin
				org_s3[i] <= org_s2[i];
				for (int j = 0; j < 3; j++)
					term_s3[i][j] <= (ACC_W'(phi_s2[i][j]) <<< LO_W) + ACC_W'(plo_s2[i][j]);
			end
			// Stage 4: dot product, origin term and rounding offset.
			for (int i = 0; i < 3; i++)
				sum_s4[i] <= term_s3[i][0] + term_s3[i][1] + term_s3[i][2]
					+ (ACC_W'(org_s3[i]) <<< 30) + ACC_W'(64'sd536870912);
			// Output register: drop the fraction and saturate.
			for (int i = 0; i < 3; i++) begin
				if ((&shv[i][ACC_W-1:W-1]) || !(|shv[i][ACC_W-1:W-1]))
					res_q[i] <= shv[i][W-1:0];
				else if (shv[i][ACC_W-1])
					res_q[i] <= {1'b1, {(W-1){1'b0}}};
				else
					res_q[i] <= {1'b0, {(W-1){1'b1}}};
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !points.ready)
		else $error("point accepted while the matrix is being rebuilt");
	a_angle_restart: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> (state_q == S_PREP))
		else $error("angle write did not restart the matrix sequencer");
	a_enter_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v_s1)
		else $error("accepted item did not enter the first stage");
`endif

endmodule
